// ===== hw/rtl/bec_pkg.sv =====
// ----------------------------------------------------------------------------
// bec_pkg
// shared types and constants for the bus error confinement unit
// ----------------------------------------------------------------------------
package bec_pkg;

   localparam int unsigned CNT_W    = 9;
   localparam int unsigned RECOV_W  = 16;
   localparam int unsigned ID_W     = 32;
   localparam int unsigned RETRY_W  = 8;
   localparam int unsigned OPCODE_W = 3;
   localparam int unsigned STATE_W  = 2;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_TICK    = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_ERROR   = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_ACK     = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_TIMEOUT = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_SEND    = 3'd4;

   // confinement states
   localparam logic [STATE_W-1:0] ST_ACTIVE  = 2'd0;
   localparam logic [STATE_W-1:0] ST_PASSIVE = 2'd1;
   localparam logic [STATE_W-1:0] ST_BUSOFF  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_ID     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PASSIVE_THR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BUSOFF_THR  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RECOV_TICKS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_LIMIT = 3'd4;

   // register reset values
   localparam logic [ID_W-1:0]    RST_NODE_ID     = 32'd1;
   localparam logic [CNT_W-1:0]   RST_PASSIVE_THR = 9'd128;
   localparam logic [CNT_W-1:0]   RST_BUSOFF_THR  = 9'd256;
   localparam logic [RECOV_W-1:0] RST_RECOV_TICKS = 16'd128;
   localparam logic [RETRY_W-1:0] RST_RETRY_LIMIT = 8'd3;

   localparam logic [CNT_W:0] CNT_MAX     = 10'd511;
   localparam logic [CNT_W:0] TX_ERR_STEP = 10'd8;

   typedef struct packed {
      logic [ID_W-1:0]    node_id;
      logic [CNT_W-1:0]   passive_threshold;
      logic [CNT_W-1:0]   busoff_threshold;
      logic [RECOV_W-1:0] recovery_ticks;
      logic [RETRY_W-1:0] retry_limit;
   } cfg_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [ID_W-1:0]     dest_id;
      logic                is_broadcast;
      logic [RETRY_W-1:0]  retry_count;
   } req_item_type;

   typedef struct packed {
      logic [STATE_W-1:0] error_state;
      logic [CNT_W-1:0]   tx_errors;
      logic [CNT_W-1:0]   rx_errors;
      logic               accepted;
      logic               passive_mark;
   } rsp_item_type;

endpackage

// ===== hw/rtl/bec_req_if.sv =====
// ----------------------------------------------------------------------------
// bec_req_if
// event channel: valid/ready with one event per beat
// ----------------------------------------------------------------------------
interface bec_req_if;
   logic                               valid;
   logic                               ready;
   logic [bec_pkg::OPCODE_W-1:0]       opcode;
   logic [bec_pkg::ID_W-1:0]           dest_id;
   logic                               is_broadcast;
   logic [bec_pkg::RETRY_W-1:0]        retry_count;

   modport source (output valid, output opcode, output dest_id, output is_broadcast,
                   output retry_count, input ready);
   modport sink   (input valid, input opcode, input dest_id, input is_broadcast,
                   input retry_count, output ready);
endinterface

// ===== hw/rtl/bec_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bec_rsp_if
// result channel: valid/ready with one result per beat
// ----------------------------------------------------------------------------
interface bec_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bec_pkg::STATE_W-1:0]   error_state;
   logic [bec_pkg::CNT_W-1:0]     tx_errors;
   logic [bec_pkg::CNT_W-1:0]     rx_errors;
   logic                          accepted;
   logic                          passive_mark;

   modport source (output valid, output error_state, output tx_errors, output rx_errors,
                   output accepted, output passive_mark, input ready);
   modport sink   (input valid, input error_state, input tx_errors, input rx_errors,
                   input accepted, input passive_mark, output ready);
endinterface

// ===== hw/rtl/bec_csr.sv =====
// ----------------------------------------------------------------------------
// bec_csr
// configuration register file, write only
// ----------------------------------------------------------------------------
module bec_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [bec_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bec_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output bec_pkg::cfg_type                  cfg
);

   bec_pkg::cfg_type cfg_ff;
   bec_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            bec_pkg::CSR_NODE_ID:
               cfg_in.node_id = csr_wdata;
            bec_pkg::CSR_PASSIVE_THR:
               cfg_in.passive_threshold = csr_wdata[bec_pkg::CNT_W-1:0];
            bec_pkg::CSR_BUSOFF_THR:
               cfg_in.busoff_threshold = csr_wdata[bec_pkg::CNT_W-1:0];
            bec_pkg::CSR_RECOV_TICKS:
               cfg_in.recovery_ticks = csr_wdata[bec_pkg::RECOV_W-1:0];
            bec_pkg::CSR_RETRY_LIMIT:
               cfg_in.retry_limit = csr_wdata[bec_pkg::RETRY_W-1:0];
            default: ; // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_id           <= bec_pkg::RST_NODE_ID;
         cfg_ff.passive_threshold <= bec_pkg::RST_PASSIVE_THR;
         cfg_ff.busoff_threshold  <= bec_pkg::RST_BUSOFF_THR;
         cfg_ff.recovery_ticks    <= bec_pkg::RST_RECOV_TICKS;
         cfg_ff.retry_limit       <= bec_pkg::RST_RETRY_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/bec_core.sv =====
// ----------------------------------------------------------------------------
// bec_core
// confinement state, error counters and recovery countdown
// ----------------------------------------------------------------------------
module bec_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  bec_pkg::req_item_type  item,
   input  bec_pkg::cfg_type       cfg,
   output bec_pkg::rsp_item_type  result
);

   logic [bec_pkg::CNT_W-1:0]   tx_ff, tx_in;
   logic [bec_pkg::CNT_W-1:0]   rx_ff, rx_in;
   logic [bec_pkg::STATE_W-1:0] st_ff, st_in;
   logic [bec_pkg::RECOV_W-1:0] rl_ff, rl_in;

   logic                   dest_hit;
   logic                   for_me;
   logic                   busoff;
   logic                   judge;
   logic                   acc;
   logic                   pmark;
   logic [bec_pkg::CNT_W:0] tx_sum;
   logic [bec_pkg::CNT_W:0] rx_sum;
   logic [bec_pkg::CNT_W:0] tx_step;

   assign dest_hit = (item.dest_id == cfg.node_id);
   assign for_me   = item.is_broadcast | dest_hit;
   assign busoff   = (st_ff == bec_pkg::ST_BUSOFF);
   assign tx_step  = (item.opcode == bec_pkg::OP_ERROR) ? bec_pkg::TX_ERR_STEP
                                                        : (bec_pkg::CNT_W+1)'(1);
   assign tx_sum   = {1'b0, tx_ff} + tx_step;
   assign rx_sum   = {1'b0, rx_ff} + (bec_pkg::CNT_W+1)'(1);

   always_comb begin
      tx_in = tx_ff;
      rx_in = rx_ff;
      st_in = st_ff;
      rl_in = rl_ff;
      judge = 1'b0;
      acc   = 1'b0;
      pmark = 1'b0;

      unique case (item.opcode)
         bec_pkg::OP_TICK: begin
            if (busoff) begin
               if (rl_ff <= bec_pkg::RECOV_W'(1)) begin
                  tx_in = '0;
                  rx_in = '0;
                  rl_in = '0;
                  st_in = bec_pkg::ST_ACTIVE;
               end else begin
                  rl_in = rl_ff - bec_pkg::RECOV_W'(1);
               end
            end
         end
         bec_pkg::OP_ERROR: begin
            if (!busoff && for_me) begin
               if (dest_hit) begin
                  tx_in = (tx_sum > bec_pkg::CNT_MAX) ? bec_pkg::CNT_MAX[bec_pkg::CNT_W-1:0]
                                                      : tx_sum[bec_pkg::CNT_W-1:0];
               end else begin
                  rx_in = (rx_sum > bec_pkg::CNT_MAX) ? bec_pkg::CNT_MAX[bec_pkg::CNT_W-1:0]
                                                      : rx_sum[bec_pkg::CNT_W-1:0];
               end
               judge = 1'b1;
               acc   = 1'b1;
            end
         end
         bec_pkg::OP_ACK: begin
            if (!busoff && for_me) begin
               if (tx_ff != '0) begin
                  tx_in = tx_ff - bec_pkg::CNT_W'(1);
               end
               judge = 1'b1;
               acc   = 1'b1;
            end
         end
         bec_pkg::OP_TIMEOUT: begin
            tx_in = (tx_sum > bec_pkg::CNT_MAX) ? bec_pkg::CNT_MAX[bec_pkg::CNT_W-1:0]
                                                : tx_sum[bec_pkg::CNT_W-1:0];
            judge = 1'b1;
            acc   = 1'b1;
         end
         bec_pkg::OP_SEND: begin
            if (!busoff && (item.retry_count <= cfg.retry_limit)) begin
               acc   = 1'b1;
               pmark = (st_ff == bec_pkg::ST_PASSIVE);
            end
         end
         default: ; // unused opcodes leave everything alone
      endcase

      // re-judge state after a counter event; bus-off only leaves by recovery
      if (judge && !busoff) begin
         if (tx_in >= cfg.busoff_threshold) begin
            st_in = bec_pkg::ST_BUSOFF;
            rl_in = cfg.recovery_ticks;
         end else if (tx_in >= cfg.passive_threshold || rx_in >= cfg.passive_threshold) begin
            st_in = bec_pkg::ST_PASSIVE;
         end else begin
            st_in = bec_pkg::ST_ACTIVE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_ff <= '0;
         rx_ff <= '0;
         st_ff <= bec_pkg::ST_ACTIVE;
         rl_ff <= '0;
      end else if (advance) begin
         tx_ff <= tx_in;
         rx_ff <= rx_in;
         st_ff <= st_in;
         rl_ff <= rl_in;
      end
   end

   assign result.error_state  = st_in;
   assign result.tx_errors    = tx_in;
   assign result.rx_errors    = rx_in;
   assign result.accepted     = acc;
   assign result.passive_mark = pmark;

endmodule

// ===== hw/rtl/bus_error_confinement_unit.sv =====
// ----------------------------------------------------------------------------
// bus_error_confinement_unit
// fault confinement for a bus node: transmit and receive error counters,
// active / passive / bus-off state and bus-off recovery countdown
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake       carries
//   req_ch    in          valid / ready   opcode, dest_id, is_broadcast, retry_count
//   rsp_ch    out         valid / ready   error_state, tx_errors, rx_errors,
//                                         accepted, passive_mark
//   csr_*     in          write enable    register index and write data
//
// one event beat per cycle sustained while rsp_ch takes results; an accepted event
// waits in the input register, then its result loads into the result register
// synchronous active-high reset clears counters, state, countdown, valid flags and
// config registers; a stalled rsp_ch holds the result register; req_ch keeps taking
// beats until the input register is also full, then ready drops
//
module bus_error_confinement_unit (
   input  logic                            clock,
   input  logic                            reset,
   bec_req_if.sink                         req_ch,
   bec_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [bec_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bec_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   bec_pkg::cfg_type      cfg;
   bec_pkg::req_item_type in_item_ff, in_item_in;
   bec_pkg::rsp_item_type out_item_ff, out_item_in;
   bec_pkg::rsp_item_type core_result;
   logic                  in_vld_ff, in_vld_in;
   logic                  out_vld_ff, out_vld_in;
   logic                  advance;
   logic                  req_fire;

   // config registers
   bec_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // item moves from the input register into the result register
   assign advance  = in_vld_ff & (~out_vld_ff | rsp_ch.ready);
   assign req_fire = req_ch.valid & req_ch.ready;

   assign req_ch.ready = ~in_vld_ff | advance;

   always_comb begin
      in_item_in = in_item_ff;
      if (req_fire) begin
         in_item_in.opcode       = req_ch.opcode;
         in_item_in.dest_id      = req_ch.dest_id;
         in_item_in.is_broadcast = req_ch.is_broadcast;
         in_item_in.retry_count  = req_ch.retry_count;
      end
      in_vld_in = req_fire | (in_vld_ff & ~advance);
   end

   // state update and result computation
   bec_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (core_result)
   );

   always_comb begin
      out_item_in = advance ? core_result : out_item_ff;
      out_vld_in  = advance | (out_vld_ff & ~rsp_ch.ready);
   end

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_ch.valid        = out_vld_ff;
   assign rsp_ch.error_state  = out_item_ff.error_state;
   assign rsp_ch.tx_errors    = out_item_ff.tx_errors;
   assign rsp_ch.rx_errors    = out_item_ff.rx_errors;
   assign rsp_ch.accepted     = out_item_ff.accepted;
   assign rsp_ch.passive_mark = out_item_ff.passive_mark;

endmodule
